// ----- sv/apsp_pkg.sv -----
// shared types, command codes and arithmetic helpers for the shortest path block
package apsp_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [5:0]         src_vertex;
      logic [5:0]         dst_vertex;
      logic signed [15:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic               unreachable;
      logic [5:0]         predecessor;
      logic               negative_cycle;
      logic [5:0]         cycle_vertex;
   } rsp_type;

   // register word index taken from paddr[2]
   localparam logic       CSR_IDX_NUM_VERTICES = 1'b0;
   localparam logic [6:0] NUM_VERTICES_RESET   = 7'd64;

   // 32-bit add that clamps to the signed range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sat_add = sum[31:0];
      end
   endfunction

endpackage

// ----- sv/apsp_mem.sv -----
// entry memory: one write port, two registered read ports
module apsp_mem #(
   parameter int AW = 12,
   parameter int DW = 39
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re_a,
   input  logic [AW-1:0] raddr_a,
   output logic [DW-1:0] rdata_a,
   input  logic          re_b,
   input  logic [AW-1:0] raddr_b,
   output logic [DW-1:0] rdata_b
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_a_ff;
   logic [DW-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read on that port
   always_ff @(posedge clock) begin
      if (re_a) begin
         rdata_a_ff <= mem[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ----- sv/apsp_csr.sv -----
// register port holding the active vertex count
module apsp_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [6:0]  num_vertices
);
   import apsp_pkg::*;

   logic [6:0] num_vertices_ff;
   logic [6:0] num_vertices_in;

   always_comb begin
      num_vertices_in = num_vertices_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_NUM_VERTICES)) begin
         num_vertices_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= NUM_VERTICES_RESET;
      end else begin
         num_vertices_ff <= num_vertices_in;
      end
   end

   assign prdata       = (paddr[2] == CSR_IDX_NUM_VERTICES) ? 32'(num_vertices_ff) : 32'd0;
   assign pready       = 1'b1;
   assign num_vertices = num_vertices_ff;

endmodule

// ----- sv/all_pairs_shortest_path.sv -----
// top level: floyd-warshall all-pairs shortest path engine over an entry memory
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data  (cmd, src, dst, weight)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (distance, flags, vertices)
//   csr     | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// load: written on acceptance; query: one memory read, then the response
// clear: one memory entry per cycle over 2**(2*VW) entries (4096 at 64 vertices)
// run: V diagonal writes, a read and test per (k,i) row check, and per j on
//   reachable rows (read, saturating add, compare/write), then up to V checks
// reset: clears all 2**(2*VW) entries (4096 at 64 vertices), no req accepted
// a stalled rsp holds the output register; a new req is taken once it drains
module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  apsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apsp_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import apsp_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int AW = 2 * VW;
   localparam int DW = 1 + VW + 32;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_QRY     = 12'b0000_0000_0010,
      ST_CLR     = 12'b0000_0000_0100,
      ST_DIAG    = 12'b0000_0000_1000,
      ST_ROW_RD  = 12'b0000_0001_0000,
      ST_ROW_CHK = 12'b0000_0010_0000,
      ST_J_RD    = 12'b0000_0100_0000,
      ST_J_ADD   = 12'b0000_1000_0000,
      ST_J_WR    = 12'b0001_0000_0000,
      ST_CHK_RD  = 12'b0010_0000_0000,
      ST_CHK_TST = 12'b0100_0000_0000,
      ST_RESP    = 12'b1000_0000_0000
   } state_type;

   // configuration
   logic [6:0]    num_vertices;
   logic [VW-1:0] n_last;

   // memory ports
   logic          we;
   logic [AW-1:0] waddr;
   logic [DW-1:0] wdata;
   logic          re_a;
   logic [AW-1:0] raddr_a;
   logic [DW-1:0] rdata_a;
   logic          re_b;
   logic [AW-1:0] raddr_b;
   logic [DW-1:0] rdata_b;

   logic               flag_a;
   logic [VW-1:0]      pred_a;
   logic signed [31:0] dist_a;

   // request decode
   logic          accept;
   logic          out_free;
   logic          in_range;
   logic [VW-1:0] src_v;
   logic [VW-1:0] dst_v;
   logic          last_i;
   logic          last_j;
   logic          last_k;
   logic          relax_upd;

   // registers
   state_type          state_ff,     state_in;
   logic [VW-1:0]      i_ff,         i_in;
   logic [VW-1:0]      j_ff,         j_in;
   logic [VW-1:0]      k_ff,         k_in;
   logic [AW-1:0]      clr_cnt_ff,   clr_cnt_in;
   logic               clr_cmd_ff,   clr_cmd_in;
   logic signed [31:0] ik_dist_ff,   ik_dist_in;
   logic signed [31:0] cand_ff,      cand_in;
   logic               kj_ok_ff,     kj_ok_in;
   logic [VW-1:0]      kj_pred_ff,   kj_pred_in;
   logic               ij_ok_ff,     ij_ok_in;
   logic signed [31:0] ij_dist_ff,   ij_dist_in;
   logic               neg_ff,       neg_in;
   logic [VW-1:0]      where_ff,     where_in;
   logic               q_inrange_ff, q_inrange_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,       rsp_in;

   apsp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .num_vertices (num_vertices)
   );

   apsp_mem #(
      .AW (AW),
      .DW (DW)
   ) u_mem (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .re_a    (re_a),
      .raddr_a (raddr_a),
      .rdata_a (rdata_a),
      .re_b    (re_b),
      .raddr_b (raddr_b),
      .rdata_b (rdata_b)
   );

   // last active vertex: count of zero acts as one, large counts clamp
   always_comb begin
      if (num_vertices == 7'd0) begin
         n_last = '0;
      end else if (32'(num_vertices) > MAX_VERTICES) begin
         n_last = VW'(MAX_VERTICES - 1);
      end else begin
         n_last = VW'(num_vertices - 7'd1);
      end
   end

   // entry word layout: reach flag, predecessor, distance
   assign flag_a = rdata_a[DW-1];
   assign pred_a = rdata_a[DW-2 -: VW];
   assign dist_a = rdata_a[31:0];

   assign src_v    = VW'(req_data.src_vertex);
   assign dst_v    = VW'(req_data.dst_vertex);
   assign in_range = (32'(req_data.src_vertex) < MAX_VERTICES) &&
                     (32'(req_data.dst_vertex) < MAX_VERTICES);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign last_i = (i_ff == n_last);
   assign last_j = (j_ff == n_last);
   assign last_k = (k_ff == n_last);

   // take the candidate when (k,j) is reachable and (i,j) is missing or longer
   assign relax_upd = kj_ok_ff && (!ij_ok_ff || (ij_dist_ff > cand_ff));

   // memory port selection
   always_comb begin
      we      = 1'b0;
      waddr   = {i_ff, j_ff};
      wdata   = {1'b1, kj_pred_ff, cand_ff};
      re_a    = 1'b0;
      raddr_a = {i_ff, k_ff};
      re_b    = 1'b0;
      raddr_b = {i_ff, j_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.cmd == CMD_LOAD) && in_range) begin
               we    = 1'b1;
               waddr = {src_v, dst_v};
               wdata = {1'b1, src_v, 32'(req_data.edge_weight)};
            end
            if (accept && (req_data.cmd == CMD_QUERY)) begin
               re_a    = 1'b1;
               raddr_a = {src_v, dst_v};
            end
         end
         ST_CLR: begin
            we    = 1'b1;
            waddr = clr_cnt_ff;
            wdata = '0;
         end
         ST_DIAG: begin
            we    = 1'b1;
            waddr = {i_ff, i_ff};
            wdata = {1'b1, i_ff, 32'sd0};
         end
         ST_ROW_RD: begin
            re_a    = 1'b1;
            raddr_a = {i_ff, k_ff};
         end
         ST_J_RD: begin
            re_a    = 1'b1;
            raddr_a = {k_ff, j_ff};
            re_b    = 1'b1;
            raddr_b = {i_ff, j_ff};
         end
         ST_J_WR: begin
            we = relax_upd;
         end
         ST_CHK_RD: begin
            re_a    = 1'b1;
            raddr_a = {i_ff, i_ff};
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_cmd_in   = clr_cmd_ff;
      ik_dist_in   = ik_dist_ff;
      cand_in      = cand_ff;
      kj_ok_in     = kj_ok_ff;
      kj_pred_in   = kj_pred_ff;
      ij_ok_in     = ij_ok_ff;
      ij_dist_in   = ij_dist_ff;
      neg_in       = neg_ff;
      where_in     = where_ff;
      q_inrange_in = q_inrange_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_cmd_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  CMD_LOAD: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_RUN: begin
                     i_in     = '0;
                     state_in = ST_DIAG;
                  end
                  CMD_QUERY: begin
                     q_inrange_in = in_range;
                     state_in     = ST_QRY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QRY: begin
            if (out_free) begin
               rsp_in = '0;
               if (q_inrange_ff && flag_a) begin
                  rsp_in.distance    = dist_a;
                  rsp_in.predecessor = 6'(pred_a);
               end else begin
                  rsp_in.unreachable = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               neg_in   = 1'b0;
               where_in = '0;
               state_in = clr_cmd_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_DIAG: begin
            i_in = i_ff + 1'b1;
            if (last_i) begin
               i_in     = '0;
               k_in     = '0;
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            state_in = ST_ROW_CHK;
         end
         ST_ROW_CHK: begin
            if (flag_a) begin
               ik_dist_in = dist_a;
               j_in       = '0;
               state_in   = ST_J_RD;
            end else if (!last_i) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW_RD;
            end else if (!last_k) begin
               i_in     = '0;
               k_in     = k_ff + 1'b1;
               state_in = ST_ROW_RD;
            end else begin
               i_in     = '0;
               state_in = ST_CHK_RD;
            end
         end
         ST_J_RD: begin
            state_in = ST_J_ADD;
         end
         ST_J_ADD: begin
            kj_ok_in   = flag_a;
            kj_pred_in = pred_a;
            cand_in    = sat_add(ik_dist_ff, dist_a);
            ij_ok_in   = rdata_b[DW-1];
            ij_dist_in = rdata_b[31:0];
            state_in   = ST_J_WR;
         end
         ST_J_WR: begin
            // the (i,k) entry itself may improve mid-row; later j see the new value
            if (relax_upd && (j_ff == k_ff)) begin
               ik_dist_in = cand_ff;
            end
            if (!last_j) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_J_RD;
            end else if (!last_i) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW_RD;
            end else if (!last_k) begin
               i_in     = '0;
               k_in     = k_ff + 1'b1;
               state_in = ST_ROW_RD;
            end else begin
               i_in     = '0;
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_TST;
         end
         ST_CHK_TST: begin
            if (!flag_a || (dist_a != 32'sd0)) begin
               neg_in   = 1'b1;
               where_in = i_ff;
               state_in = ST_RESP;
            end else if (last_i) begin
               neg_in   = 1'b0;
               where_in = '0;
               state_in = ST_RESP;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CHK_RD;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in                = '0;
               rsp_in.negative_cycle = neg_ff;
               rsp_in.cycle_vertex   = 6'(where_ff);
               rsp_valid_in          = 1'b1;
               clr_cmd_in            = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      ik_dist_ff   <= ik_dist_in;
      cand_ff      <= cand_in;
      kj_ok_ff     <= kj_ok_in;
      kj_pred_ff   <= kj_pred_in;
      ij_ok_ff     <= ij_ok_in;
      ij_dist_ff   <= ij_dist_in;
      neg_ff       <= neg_in;
      where_ff     <= where_in;
      q_inrange_ff <= q_inrange_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
